// File: hw/rtl/pair_histogram_tv_distance_assert.svh
// Assertion macros used by the checker module of the pair histogram block.
// Depends on nothing; pulled in by `include.
`ifndef PAIR_HISTOGRAM_TV_DISTANCE_ASSERT_SVH
`define PAIR_HISTOGRAM_TV_DISTANCE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PHTV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define PHTV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked during reset too
`define PHTV_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/phtv_pkg.sv
// Types and constants of the pair histogram distance block.
// Depends on nothing.
`default_nettype none
package phtv_pkg;
  localparam int CELL_W = 11;
  localparam int SAMP_W = 11;
  localparam int LEN_W  = 8;
  localparam int RES_W  = 9;
  localparam int OP_W   = 3;
  localparam int DIST_W = 17;
  localparam int CFGI_W = 2;
  localparam logic [DIST_W-1:0] Q_ONE = 17'h10000;
  localparam logic [CELL_W-1:0] CELL_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 3'd0,
    OP_ADD_A = 3'd1,
    OP_ADD_B = 3'd2,
    OP_QROW  = 3'd3,
    OP_QCOL  = 3'd4
  } op_t;

  typedef enum logic [CFGI_W-1:0] {
    CFG_LEN_FIRST  = 2'd0,
    CFG_LEN_SECOND = 2'd1,
    CFG_SAMPLES_A  = 2'd2,
    CFG_SAMPLES_B  = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_ADD_RD,
    S_ADD_WR,
    S_WALK,
    S_DRAIN,
    S_DIV
  } state_t;
endpackage
`default_nettype wire

// File: hw/rtl/pair_histogram_tv_distance.sv
// Top level of the pair histogram total variation distance block.
// Depends on phtv_pkg, phtv_ram and phtv_div.
//
// Two count memories (one per sample set) hold (MAX_LEN+1)^2 cells each. After
// reset, and after an accepted clear, busy stays high while a sweep zeroes both
// memories, one cell per cycle (65536 cells at the default). An add keeps busy
// high through a read and then a write of the incremented cell through the
// single memory port, so a new add is taken only once that write is done. A
// query walks one row or column at one cell per cycle (len+1 cells), then the
// read-valid and multiply/accumulate stages drain and the serial divider works
// out the quotient bit by bit (it skips the iteration when the distance
// saturates). The result beat is on out_valid for one cycle and cannot be
// stalled; the next beat can be taken at the end of that cycle.
`default_nettype none
module pair_histogram_tv_distance
  import phtv_pkg::*;
#(
  parameter int MAX_LEN     = 255,
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [OP_W-1:0]      in_operation,
  input  wire logic [RES_W-1:0]     in_residue_first,
  input  wire logic [RES_W-1:0]     in_residue_second,
  output logic                      out_valid,
  output logic                      out_axis,
  output logic [LEN_W-1:0]          out_position,
  output logic [DIST_W-1:0]         out_distance,
  input  wire logic                 cfg_we,
  input  wire logic [CFGI_W-1:0]    cfg_index,
  input  wire logic [SAMP_W-1:0]    cfg_data
);
  localparam int DIM   = MAX_LEN + 1;
  localparam int DEPTH = DIM * DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int PW    = CELL_W + SAMP_W;
  localparam int SUMW  = PW + LEN_W + 1;
  localparam int DW    = 2 * SAMP_W + 1;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  len_first_r, len_second_r;
  logic [SAMP_W-1:0] samples_a_r, samples_b_r;
  logic [LEN_W-1:0]  l1, l2;
  logic [SAMP_W-1:0] na, nb;

  logic [AW-1:0]     addr_r;
  logic [AW-1:0]     step_r;
  logic [LEN_W:0]    cnt_r;
  logic              tgt_b_r;
  logic              rd_v_r, mv_r;
  logic [PW-1:0]     pa_r, pb_r;
  logic [SUMW-1:0]   acc_r;
  logic [DW-1:0]     den_r;
  logic              axis_r;
  logic [LEN_W-1:0]  pos_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] dist_r;

  logic signed [RES_W:0] p1x, p2x;
  logic              add_ok, qrow_ok, qcol_ok;
  logic [IW-1:0]     idx1, idx2;
  logic [AW-1:0]     cell_addr;
  logic              accept;

  logic              we_a, we_b;
  logic [CELL_W-1:0] wdata;
  logic [CELL_W-1:0] rd_a, rd_b, rd_sel;
  logic              div_start, div_done;
  logic [DIST_W-1:0] div_q;
  logic [PW-1:0]     term;

  assign l1 = (32'(len_first_r)  > MAX_LEN) ? LEN_W'(MAX_LEN) : len_first_r;
  assign l2 = (32'(len_second_r) > MAX_LEN) ? LEN_W'(MAX_LEN) : len_second_r;
  assign na = (samples_a_r == '0) ? SAMP_W'(1) :
              (32'(samples_a_r) > MAX_SAMPLES) ? SAMP_W'(MAX_SAMPLES) : samples_a_r;
  assign nb = (samples_b_r == '0) ? SAMP_W'(1) :
              (32'(samples_b_r) > MAX_SAMPLES) ? SAMP_W'(MAX_SAMPLES) : samples_b_r;

  assign p1x = {in_residue_first[RES_W-1], in_residue_first} + (RES_W+1)'(1);
  assign p2x = {in_residue_second[RES_W-1], in_residue_second} + (RES_W+1)'(1);
  assign add_ok  = !p1x[RES_W] && !p2x[RES_W] &&
                   (p1x <= $signed({2'b00, l1})) && (p2x <= $signed({2'b00, l2}));
  assign qrow_ok = !in_residue_first[RES_W-1]  && (in_residue_first[LEN_W-1:0] < l1);
  assign qcol_ok = !in_residue_second[RES_W-1] && (in_residue_second[LEN_W-1:0] < l2);
  assign idx1 = IW'(unsigned'(p1x));
  assign idx2 = IW'(unsigned'(p2x));
  assign cell_addr = AW'(int'(idx1) * DIM + int'(idx2));
  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (op_t'(in_operation)) inside
            OP_CLEAR: state_nxt = S_CLR;
            OP_ADD_A, OP_ADD_B: if (add_ok) state_nxt = S_ADD_RD;
            OP_QROW: if (qrow_ok) state_nxt = S_WALK;
            OP_QCOL: if (qcol_ok) state_nxt = S_WALK;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CLR:    if (addr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_ADD_RD: state_nxt = S_ADD_WR;
      S_ADD_WR: state_nxt = S_IDLE;
      S_WALK:   if (cnt_r == '0) state_nxt = S_DRAIN;
      S_DRAIN:  if (!rd_v_r && !mv_r) state_nxt = S_DIV;
      S_DIV:    if (div_done) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign rd_sel = tgt_b_r ? rd_b : rd_a;

  always_comb begin
    we_a      = 1'b0;
    we_b      = 1'b0;
    wdata     = '0;
    div_start = 1'b0;
    unique case (state_r)
      S_CLR: begin
        we_a = 1'b1;
        we_b = 1'b1;
      end
      S_ADD_WR: begin
        we_a  = !tgt_b_r;
        we_b  = tgt_b_r;
        wdata = (rd_sel == CELL_MAX) ? CELL_MAX : rd_sel + CELL_W'(1);
      end
      S_DRAIN: div_start = !rd_v_r && !mv_r;
      default: begin
      end
    endcase
  end

  assign term = (pa_r >= pb_r) ? (pa_r - pb_r) : (pb_r - pa_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      addr_r       <= '0;
      rd_v_r       <= 1'b0;
      mv_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      len_first_r  <= LEN_W'(255);
      len_second_r <= LEN_W'(255);
      samples_a_r  <= SAMP_W'(1);
      samples_b_r  <= SAMP_W'(1);
    end else begin
      state_r     <= state_nxt;
      rd_v_r      <= (state_r == S_WALK);
      mv_r        <= rd_v_r;
      out_valid_r <= (state_r == S_DIV) && div_done;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_LEN_FIRST:  len_first_r  <= cfg_data[LEN_W-1:0];
          CFG_LEN_SECOND: len_second_r <= cfg_data[LEN_W-1:0];
          CFG_SAMPLES_A:  samples_a_r  <= cfg_data;
          CFG_SAMPLES_B:  samples_b_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        if (op_t'(in_operation) == OP_CLEAR) begin
          addr_r <= '0;
        end else if (op_t'(in_operation) == OP_QROW) begin
          addr_r <= AW'(int'(idx1) * DIM);
        end else if (op_t'(in_operation) == OP_QCOL) begin
          addr_r <= AW'(int'(idx2));
        end else begin
          addr_r <= cell_addr;
        end
      end else if (state_r == S_CLR || state_r == S_WALK) begin
        addr_r <= addr_r + ((state_r == S_WALK) ? step_r : AW'(1));
      end
    end
    if (accept) begin
      tgt_b_r <= (op_t'(in_operation) == OP_ADD_B);
      axis_r  <= (op_t'(in_operation) == OP_QCOL);
      pos_r   <= (op_t'(in_operation) == OP_QCOL) ? in_residue_second[LEN_W-1:0]
                                                  : in_residue_first[LEN_W-1:0];
      step_r  <= (op_t'(in_operation) == OP_QCOL) ? AW'(DIM) : AW'(1);
      cnt_r   <= (op_t'(in_operation) == OP_QCOL) ? {1'b0, l1} : {1'b0, l2};
      den_r   <= {(2*SAMP_W)'(na) * (2*SAMP_W)'(nb), 1'b0};
      acc_r   <= '0;
    end else begin
      if (state_r == S_WALK) begin
        cnt_r <= cnt_r - (LEN_W+1)'(1);
      end
      if (mv_r) begin
        acc_r <= acc_r + SUMW'(term);
      end
    end
    pa_r <= rd_a * nb;
    pb_r <= rd_b * na;
    if ((state_r == S_DIV) && div_done) begin
      dist_r <= div_q;
    end
  end

  phtv_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_hist_a (
    .clk   (clk),
    .we    (we_a),
    .addr  (addr_r),
    .wdata (wdata),
    .rdata (rd_a)
  );

  phtv_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_hist_b (
    .clk   (clk),
    .we    (we_b),
    .addr  (addr_r),
    .wdata (wdata),
    .rdata (rd_b)
  );

  phtv_div #(.NW(SUMW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_q)
  );

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_axis     = axis_r;
  assign out_position = pos_r;
  assign out_distance = dist_r;
endmodule
`default_nettype wire

// File: hw/rtl/phtv_ram.sv
// Generic single-port synchronous RAM with registered read.
// Depends on nothing.
`default_nettype none
module phtv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: hw/rtl/phtv_div.sv
// Iterative Q1.16 divider: floor(num * 2^16 / den), saturated at 1.0.
// Depends on phtv_pkg.
`default_nettype none
module phtv_div
  import phtv_pkg::*;
#(
  parameter int NW = 30,
  parameter int DW = 23
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [NW-1:0]     num,
  input  wire logic [DW-1:0]     den,
  output logic                   done,
  output logic [DIST_W-1:0]      quot
);
  localparam int RW  = DW + 1;
  localparam int CMW = (NW > RW) ? NW : RW;

  logic              busy_r;
  logic              first_r;
  logic [4:0]        cnt_r;
  logic [RW-1:0]     rem_r;
  logic [DIST_W-1:0] q_r;
  logic              done_r;
  logic [DIST_W-1:0] quot_r;
  logic [RW-1:0]     t;
  logic              bit_q;
  logic [DIST_W-1:0] q_nxt;
  logic              sat;

  assign sat   = CMW'(num) >= CMW'({1'b0, den} << 1);
  assign t     = first_r ? rem_r : (rem_r << 1);
  assign bit_q = t >= RW'(den);
  assign q_nxt = {q_r[DIST_W-2:0], bit_q};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (sat) begin
          done_r <= 1'b1;
          quot_r <= Q_ONE;
        end else begin
          busy_r  <= 1'b1;
          first_r <= 1'b1;
          cnt_r   <= 5'(DIST_W - 1);
          rem_r   <= RW'(num);
          q_r     <= '0;
        end
      end else if (busy_r) begin
        first_r <= 1'b0;
        rem_r   <= bit_q ? (t - RW'(den)) : t;
        q_r     <= q_nxt;
        cnt_r   <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quot_r <= (q_nxt > Q_ONE) ? Q_ONE : q_nxt;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
endmodule
`default_nettype wire

// File: hw/rtl/phtv_checker.sv
// Port-level checker for pair_histogram_tv_distance, bound to the top level.
// Depends on phtv_pkg and pair_histogram_tv_distance_assert.svh.
`default_nettype none
`include "pair_histogram_tv_distance_assert.svh"
module phtv_checker
  import phtv_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic [OP_W-1:0]   in_operation,
  input wire logic              out_valid,
  input wire logic [DIST_W-1:0] out_distance
);
  `PHTV_ASSERT_NXT_ALWAYS(a_reset_clears, clk, !rst_n, busy)
  `PHTV_ASSERT_IMP(a_dist_range, clk, rst_n, out_valid, out_distance <= Q_ONE)
  `PHTV_ASSERT_NXT(a_single_beat, clk, rst_n, out_valid, !out_valid)
  `PHTV_ASSERT_NXT(a_clear_busy, clk, rst_n,
                   start && !busy && (in_operation == OP_CLEAR), busy)
  `PHTV_ASSERT_IMP(a_result_after_work, clk, rst_n, out_valid, $past(busy))
endmodule

bind pair_histogram_tv_distance phtv_checker u_phtv_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_operation (in_operation),
  .out_valid    (out_valid),
  .out_distance (out_distance)
);
`default_nettype wire
